### src/rlwl_pkg.sv
`default_nettype none
package rlwl_pkg;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_TARGET_LEVEL = 1'b0;
    localparam logic REG_SMOOTHING    = 1'b1;
    localparam logic [14:0] TARGET_RESET = 15'd3277;

    // item codes
    localparam logic OP_ANALYSIS = 1'b0;
    localparam logic OP_PROCESS  = 1'b1;
    localparam logic RES_GAIN    = 1'b0;
    localparam logic RES_SAMPLE  = 1'b1;

    // gain arithmetic
    localparam logic [15:0] UNITY_GAIN    = 16'd8192;
    localparam logic [15:0] GAIN_CAP      = 16'd32768;
    localparam logic [29:0] RMS_THRESHOLD = 30'd105;
    localparam logic signed [17:0] COEF_NEW = 18'sd19661;
    localparam logic signed [17:0] COEF_OLD = 18'sd13107;
    localparam int SUM_W   = 50;
    localparam int COUNT_W = 21;

    // divide / root unit
    localparam int NUM_W  = 60;
    localparam int DEN_W  = 30;
    localparam int REM_W  = 34;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] MEAN_STEPS = 6'd60;
    localparam logic [STEP_W-1:0] ROOT_STEPS = 6'd30;
    localparam logic [STEP_W-1:0] GAIN_STEPS = 6'd33;

    typedef enum logic {
        DSU_DIV,
        DSU_SQRT
    } t_dsu_mode;

    typedef struct packed {
        logic              start;
        t_dsu_mode         mode;
        logic [STEP_W-1:0] steps;
    } t_dsu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dsu_rsp;

    typedef struct packed {
        logic [14:0] target_level;
        logic        smoothing_enable;
    } t_cfg;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] sample_in;
        logic               channel;
        logic               first_of_channel;
        logic               last_of_clip;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] sample_out;
        logic               channel_out;
        logic [15:0]        gain_out;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_MEAN,
        S_MEAN_W,
        S_ROOT,
        S_ROOT_W,
        S_GAIN,
        S_GAIN_W,
        S_SCALE,
        S_LP1,
        S_LP2,
        S_LP3,
        S_EMIT
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/rms_leveling_with_lowpass.sv
`default_nettype none
// RMS leveling with optional one-pole lowpass.
// Input channel (i_in_valid / o_in_ready / i_in_item): one audio sample per item.
// The clip goes through twice: analysis items (operation 0) accumulate squares,
// and the item marked last_of_clip triggers the gain calculation and a gain
// report item. Processing items (operation 1) are scaled by the gain, optionally
// smoothed per channel, and return one processed-sample item each.
// Output channel (o_out_valid / i_out_ready / o_out_item) is a single output
// register; the next input item is taken while a result still waits there.
// Flow: one item at a time, o_in_ready low while it is worked on.
//   analysis sample, not last: multiply, accumulate
//   processing sample: multiply, scale, the lowpass steps when enabled, emit
//   last analysis sample: also mean, root and gain division on the shared divide/root unit
//   (60 steps for the mean, 30 for the root, 33 for the gain division);
//   the gain division is skipped when the RMS is under the floor
// A receiver stall holds a finished result in the output register; the block
// then waits in its emit step before taking the item after next.
// Reset (i_rst_n low, synchronous) clears accumulators, sets unity gain,
// zeroes the lowpass history and restores register defaults. pready is tied high.
module rms_leveling_with_lowpass #(
    parameter int CHANNELS         = 2,
    parameter int MAX_CLIP_SAMPLES = 1048576
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input items
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  rlwl_pkg::t_in_item               i_in_item,
    // result items
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output rlwl_pkg::t_out_item              o_out_item,
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [rlwl_pkg::ADDR_W-1:0]      paddr,
    input  wire  [rlwl_pkg::DATA_W-1:0]      pwdata,
    output logic [rlwl_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // accumulation stops at the smaller of the clip limit and the counter limit
    localparam logic [rlwl_pkg::COUNT_W-1:0] COUNT_LIMIT =
        (MAX_CLIP_SAMPLES < 2097151) ? rlwl_pkg::COUNT_W'(MAX_CLIP_SAMPLES) : 21'h1FFFFF;

    rlwl_pkg::t_cfg       w_cfg;
    rlwl_pkg::t_state     r_state, n_state;
    rlwl_pkg::t_in_item   r_item;
    rlwl_pkg::t_dsu_req   w_req;
    rlwl_pkg::t_dsu_rsp   w_rsp;
    logic [rlwl_pkg::NUM_W-1:0] w_num;
    logic [rlwl_pkg::DEN_W-1:0] w_den;
    logic [rlwl_pkg::NUM_W-1:0] w_quot;

    logic [rlwl_pkg::SUM_W-1:0]   r_sum;
    logic [rlwl_pkg::COUNT_W-1:0] r_count;
    logic [15:0]                  r_gain;
    logic signed [15:0]           r_prev [CHANNELS];
    logic [rlwl_pkg::NUM_W-1:0]   r_mean;
    logic [rlwl_pkg::DEN_W-1:0]   r_rms;

    logic signed [35:0] r_prod;
    logic signed [35:0] r_acc;
    logic signed [17:0] r_x;
    logic signed [18:0] r_y;

    logic                r_out_valid;
    rlwl_pkg::t_out_item r_out_item;
    rlwl_pkg::t_out_item w_out_item;

    logic               w_accept;
    logic               w_load;
    logic [CH_W-1:0]    w_idx;
    logic signed [17:0] w_mul_a, w_mul_b;
    logic signed [35:0] w_mul_p;
    logic signed [35:0] w_scaled;
    logic signed [35:0] w_lp;
    logic [rlwl_pkg::SUM_W:0] w_sum;
    logic signed [15:0] w_sat;

    rlwl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    rlwl_dsu u_dsu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_rsp   (w_rsp),
        .o_quot  (w_quot)
    );

    assign pready     = 1'b1;
    assign o_in_ready = (r_state == rlwl_pkg::S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;
    // channel wraps onto the history store
    assign w_idx      = (CHANNELS == 1) ? '0 : CH_W'(r_item.channel);

    // shared 18x18 multiplier
    always_comb begin
        w_mul_a = {{2{r_item.sample_in[15]}}, r_item.sample_in};
        w_mul_b = {{2{r_item.sample_in[15]}}, r_item.sample_in};
        if (r_state == rlwl_pkg::S_MUL && r_item.operation == rlwl_pkg::OP_PROCESS) begin
            w_mul_b = {2'b00, r_gain};
        end else if (r_state == rlwl_pkg::S_LP1) begin
            w_mul_a = r_x;
            w_mul_b = rlwl_pkg::COEF_NEW;
        end else if (r_state == rlwl_pkg::S_LP2) begin
            w_mul_a = {{2{r_prev[w_idx][15]}}, r_prev[w_idx]};
            w_mul_b = rlwl_pkg::COEF_OLD;
        end
    end
    assign w_mul_p  = w_mul_a * w_mul_b;

    // round half up, floor shift
    assign w_scaled = (r_prod + 36'sd4096) >>> 13;
    assign w_lp     = (r_acc + r_prod + 36'sd16384) >>> 15;
    assign w_sum    = {1'b0, r_sum} + {20'b0, r_prod[30:0]};
    assign w_sat    = rlwl_pkg::sat16(r_y);

    // sequencer
    always_comb begin
        n_state   = r_state;
        w_req     = '{start: 1'b0, mode: rlwl_pkg::DSU_DIV, steps: rlwl_pkg::MEAN_STEPS};
        w_num     = {r_sum, 10'b0};
        w_den     = {9'b0, r_count};
        w_load    = 1'b0;
        unique case (r_state)
            rlwl_pkg::S_IDLE: begin
                if (w_accept) n_state = rlwl_pkg::S_MUL;
            end
            rlwl_pkg::S_MUL: begin
                n_state = (r_item.operation == rlwl_pkg::OP_PROCESS) ?
                          rlwl_pkg::S_SCALE : rlwl_pkg::S_ACC;
            end
            rlwl_pkg::S_ACC: begin
                n_state = r_item.last_of_clip ? rlwl_pkg::S_MEAN : rlwl_pkg::S_IDLE;
            end
            rlwl_pkg::S_MEAN: begin
                if (r_count == '0) begin
                    n_state = rlwl_pkg::S_ROOT;
                end else begin
                    w_req.start = 1'b1;
                    n_state     = rlwl_pkg::S_MEAN_W;
                end
            end
            rlwl_pkg::S_MEAN_W: begin
                if (w_rsp.done) n_state = rlwl_pkg::S_ROOT;
            end
            rlwl_pkg::S_ROOT: begin
                w_req   = '{start: 1'b1, mode: rlwl_pkg::DSU_SQRT, steps: rlwl_pkg::ROOT_STEPS};
                w_num   = r_mean;
                n_state = rlwl_pkg::S_ROOT_W;
            end
            rlwl_pkg::S_ROOT_W: begin
                if (w_rsp.done) n_state = rlwl_pkg::S_GAIN;
            end
            rlwl_pkg::S_GAIN: begin
                if (r_rms < rlwl_pkg::RMS_THRESHOLD) begin
                    n_state = rlwl_pkg::S_EMIT;
                end else begin
                    w_req   = '{start: 1'b1, mode: rlwl_pkg::DSU_DIV,
                                steps: rlwl_pkg::GAIN_STEPS};
                    w_num   = {w_cfg.target_level, 45'b0};
                    w_den   = r_rms;
                    n_state = rlwl_pkg::S_GAIN_W;
                end
            end
            rlwl_pkg::S_GAIN_W: begin
                if (w_rsp.done) n_state = rlwl_pkg::S_EMIT;
            end
            rlwl_pkg::S_SCALE: begin
                n_state = (w_cfg.smoothing_enable && !r_item.first_of_channel) ?
                          rlwl_pkg::S_LP1 : rlwl_pkg::S_EMIT;
            end
            rlwl_pkg::S_LP1: n_state = rlwl_pkg::S_LP2;
            rlwl_pkg::S_LP2: n_state = rlwl_pkg::S_LP3;
            rlwl_pkg::S_LP3: n_state = rlwl_pkg::S_EMIT;
            rlwl_pkg::S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = rlwl_pkg::S_IDLE;
                end
            end
            default: n_state = rlwl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlwl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result item
    always_comb begin
        if (r_item.operation == rlwl_pkg::OP_PROCESS) begin
            w_out_item = '{result_kind: rlwl_pkg::RES_SAMPLE, sample_out: w_sat,
                           channel_out: r_item.channel, gain_out: r_gain};
        end else begin
            w_out_item = '{result_kind: rlwl_pkg::RES_GAIN, sample_out: 16'sd0,
                           channel_out: 1'b0, gain_out: r_gain};
        end
    end

    // model state: accumulators, gain, lowpass history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_gain  <= rlwl_pkg::UNITY_GAIN;
            for (int i = 0; i < CHANNELS; i++) r_prev[i] <= '0;
        end else begin
            if (r_state == rlwl_pkg::S_ACC && r_count < COUNT_LIMIT) begin
                // saturate at all ones on carry out
                r_sum   <= w_sum[rlwl_pkg::SUM_W] ? '1 : w_sum[rlwl_pkg::SUM_W-1:0];
                r_count <= r_count + 1'b1;
            end
            if (r_state == rlwl_pkg::S_ROOT) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if (r_state == rlwl_pkg::S_GAIN && r_rms < rlwl_pkg::RMS_THRESHOLD) begin
                r_gain <= rlwl_pkg::UNITY_GAIN;
            end
            if (r_state == rlwl_pkg::S_GAIN_W && w_rsp.done) begin
                r_gain <= (w_quot[32:0] > 33'(rlwl_pkg::GAIN_CAP)) ?
                          rlwl_pkg::GAIN_CAP : w_quot[15:0];
            end
            // history follows the saturated output, smoothing on or off
            if (w_load && r_item.operation == rlwl_pkg::OP_PROCESS) begin
                r_prev[w_idx] <= w_sat;
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (w_accept) r_item <= i_in_item;
        unique case (r_state)
            rlwl_pkg::S_MUL, rlwl_pkg::S_LP1: r_prod <= w_mul_p;
            rlwl_pkg::S_LP2: begin
                r_acc  <= r_prod;
                r_prod <= w_mul_p;
            end
            rlwl_pkg::S_SCALE: begin
                r_x <= w_scaled[17:0];
                r_y <= {w_scaled[17], w_scaled[17:0]};
            end
            rlwl_pkg::S_LP3: r_y <= w_lp[18:0];
            rlwl_pkg::S_MEAN: begin
                if (r_count == '0) r_mean <= '0;
            end
            rlwl_pkg::S_MEAN_W: begin
                if (w_rsp.done) r_mean <= w_quot;
            end
            rlwl_pkg::S_ROOT_W: begin
                if (w_rsp.done) r_rms <= w_quot[rlwl_pkg::DEN_W-1:0];
            end
            default: ;
        endcase
        if (w_load) r_out_item <= w_out_item;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_dsu_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("divide/root unit started while busy");

    a_gain_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlwl_pkg::S_GAIN_W && w_rsp.done) |=> (r_gain <= rlwl_pkg::GAIN_CAP))
        else $error("gain above cap");

    a_count_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlwl_pkg::S_ACC) |=> (r_count <= COUNT_LIMIT))
        else $error("sample count past its limit");

endmodule
`default_nettype wire

### src/rlwl_dsu.sv
`default_nettype none
// Shared restoring divide / digit-by-digit square root, one quotient or root bit per cycle.
module rlwl_dsu (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  rlwl_pkg::t_dsu_req                i_req,
    input  wire  [rlwl_pkg::NUM_W-1:0]        i_num,
    input  wire  [rlwl_pkg::DEN_W-1:0]        i_den,
    output rlwl_pkg::t_dsu_rsp                o_rsp,
    output logic [rlwl_pkg::NUM_W-1:0]        o_quot
);

    logic                          r_busy;
    logic                          r_done;
    rlwl_pkg::t_dsu_mode           r_mode;
    logic [rlwl_pkg::STEP_W-1:0]   r_cnt;
    logic [rlwl_pkg::REM_W-1:0]    r_rem;
    logic [rlwl_pkg::NUM_W-1:0]    r_num;
    logic [rlwl_pkg::DEN_W-1:0]    r_den;
    logic [rlwl_pkg::NUM_W-1:0]    r_q;

    logic [rlwl_pkg::REM_W-1:0]    w_shift;
    logic [rlwl_pkg::REM_W-1:0]    w_sub;
    logic [rlwl_pkg::REM_W:0]      w_diff;
    logic                          w_ge;

    always_comb begin
        unique case (r_mode)
            rlwl_pkg::DSU_DIV: begin
                w_shift = {r_rem[rlwl_pkg::REM_W-2:0], r_num[rlwl_pkg::NUM_W-1]};
                w_sub   = {{(rlwl_pkg::REM_W-rlwl_pkg::DEN_W){1'b0}}, r_den};
            end
            rlwl_pkg::DSU_SQRT: begin
                w_shift = {r_rem[rlwl_pkg::REM_W-3:0], r_num[rlwl_pkg::NUM_W-1 -: 2]};
                w_sub   = {r_q[rlwl_pkg::REM_W-3:0], 2'b01};
            end
        endcase
        w_diff = {1'b0, w_shift} - {1'b0, w_sub};
        w_ge   = ~w_diff[rlwl_pkg::REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= rlwl_pkg::DSU_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_mode <= i_req.mode;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rlwl_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[rlwl_pkg::REM_W-1:0] : w_shift;
            r_q   <= {r_q[rlwl_pkg::NUM_W-2:0], w_ge};
            if (r_mode == rlwl_pkg::DSU_SQRT) begin
                r_num <= {r_num[rlwl_pkg::NUM_W-3:0], 2'b00};
            end else begin
                r_num <= {r_num[rlwl_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quot     = r_q;

endmodule
`default_nettype wire

### src/rlwl_cfg.sv
`default_nettype none
// APB register bank: target level and lowpass enable.
module rlwl_cfg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [rlwl_pkg::ADDR_W-1:0]      paddr,
    input  wire  [rlwl_pkg::DATA_W-1:0]      pwdata,
    output logic [rlwl_pkg::DATA_W-1:0]      prdata,
    output rlwl_pkg::t_cfg                   o_cfg
);

    logic [14:0] r_target;
    logic        r_smooth;
    logic        w_wr;

    assign w_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= rlwl_pkg::TARGET_RESET;
            r_smooth <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[2])
                rlwl_pkg::REG_TARGET_LEVEL: r_target <= pwdata[14:0];
                rlwl_pkg::REG_SMOOTHING:    r_smooth <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rlwl_pkg::REG_TARGET_LEVEL: prdata = {17'b0, r_target};
            rlwl_pkg::REG_SMOOTHING:    prdata = {31'b0, r_smooth};
        endcase
    end

    assign o_cfg.target_level     = r_target;
    assign o_cfg.smoothing_enable = r_smooth;

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // Bench sizing. The clip limit is pulled well below the default so that
    // over-long clips can be exercised within a short run.
    localparam int CHANNELS    = 2;
    localparam int MAX_CLIP    = 48;
    localparam int ITEM_GOAL   = 1200;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int IDLE_SETTLE = 16;    // covers a non-reporting analysis item
    localparam int END_SETTLE  = 200;   // covers a full gain calculation
    localparam int LIMIT_NS    = 2000000;

    localparam logic [rlwl_pkg::ADDR_W-1:0] ADDR_TARGET =
        {rlwl_pkg::REG_TARGET_LEVEL, 2'b00};
    localparam logic [rlwl_pkg::ADDR_W-1:0] ADDR_SMOOTH =
        {rlwl_pkg::REG_SMOOTHING, 2'b00};

    typedef longint unsigned t_u64;

    localparam t_u64 SUM_LIMIT   = (t_u64'(1) << rlwl_pkg::SUM_W) - 1;
    localparam t_u64 COUNT_LIMIT = (t_u64'(1) << rlwl_pkg::COUNT_W) - 1;

    // Tracks the leveller's state and holds the result items still owed.
    class t_scoreboard;
        rlwl_pkg::t_out_item awaited[$];
        int          failures;
        logic [14:0] target;
        logic        smooth;
        t_u64        sq_sum;
        t_u64        n_acc;
        longint      gain;               // Q3.13
        longint      last_out[CHANNELS]; // saturated output history

        function new();
            target   = rlwl_pkg::TARGET_RESET;
            smooth   = 1'b0;
            sq_sum   = 0;
            n_acc    = 0;
            gain     = longint'(rlwl_pkg::UNITY_GAIN);
            failures = 0;
            foreach (last_out[i]) last_out[i] = 0;
        endfunction

        function t_u64 root_floor(t_u64 v);
            t_u64 res;
            t_u64 probe;
            res   = 0;
            probe = t_u64'(1) << 62;
            while (probe > v) probe = probe >> 2;
            while (probe != 0) begin
                if (v >= res + probe) begin
                    v   = v - (res + probe);
                    res = (res >> 1) + probe;
                end else begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
            return res;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_sample(rlwl_pkg::t_in_item it);
            rlwl_pkg::t_out_item res;
            longint    s;
            longint    x;
            longint    y;
            t_u64      mean;
            t_u64      rms;
            t_u64      quo;
            int        idx;
            s   = longint'($signed(it.sample_in));
            res = '0;
            if (it.operation == rlwl_pkg::OP_ANALYSIS) begin
                if (n_acc < t_u64'(MAX_CLIP) && n_acc < COUNT_LIMIT) begin
                    sq_sum = sq_sum + t_u64'(s * s);
                    if (sq_sum > SUM_LIMIT) sq_sum = SUM_LIMIT;
                    n_acc++;
                end
                if (!it.last_of_clip) return;
                mean = (n_acc != 0) ? (sq_sum << 10) / n_acc : 0;
                rms  = root_floor(mean);
                if (rms >= t_u64'(rlwl_pkg::RMS_THRESHOLD)) begin
                    quo  = (t_u64'(target) << 18) / rms;
                    gain = (quo > t_u64'(rlwl_pkg::GAIN_CAP)) ?
                           longint'(rlwl_pkg::GAIN_CAP) : longint'(quo);
                end else begin
                    gain = longint'(rlwl_pkg::UNITY_GAIN);
                end
                sq_sum = 0;
                n_acc  = 0;
                res.result_kind = rlwl_pkg::RES_GAIN;
                res.gain_out    = gain[15:0];
            end else begin
                idx = int'(it.channel) % CHANNELS;
                // scale with round half up, then optional one-pole smoothing
                x = (s * gain + 4096) >>> 13;
                y = x;
                if (smooth && !it.first_of_channel) begin
                    y = (longint'(rlwl_pkg::COEF_NEW) * x
                         + longint'(rlwl_pkg::COEF_OLD) * last_out[idx] + 16384) >>> 15;
                end
                if (y > 32767) y = 32767;
                else if (y < -32768) y = -32768;
                last_out[idx] = y;
                res.result_kind = rlwl_pkg::RES_SAMPLE;
                res.sample_out  = y[15:0];
                res.channel_out = it.channel;
                res.gain_out    = gain[15:0];
            end
            awaited.push_back(res);
        endfunction

        function void check_output(rlwl_pkg::t_out_item got);
            rlwl_pkg::t_out_item want;
            if (awaited.size() == 0) begin
                $error("unexpected result item: kind %0d sample %0d gain %0d",
                       got.result_kind, got.sample_out, got.gain_out);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
                failures++;
            end
            if (got.sample_out !== want.sample_out) begin
                $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
                failures++;
            end
            if (got.channel_out !== want.channel_out) begin
                $error("channel_out: expected %0d, got %0d", want.channel_out, got.channel_out);
                failures++;
            end
            if (got.gain_out !== want.gain_out) begin
                $error("gain_out: expected %0d, got %0d", want.gain_out, got.gain_out);
                failures++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    rlwl_pkg::t_in_item          i_in_item;
    logic                        o_out_valid;
    logic                        i_out_ready;
    rlwl_pkg::t_out_item         o_out_item;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rlwl_pkg::ADDR_W-1:0] paddr;
    logic [rlwl_pkg::DATA_W-1:0] pwdata;
    logic [rlwl_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    t_scoreboard sb;
    int          items_sent;
    bit          hold_req;  // asks the receiver for one long hold-off
    bit          no_gaps;   // sender offers back to back

    rms_leveling_with_lowpass #(
        .CHANNELS         (CHANNELS),
        .MAX_CLIP_SAMPLES (MAX_CLIP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Handshakes are sampled at the edge, before any flop or driver update
    // lands, so both sides see the same values the block acted on.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_sample(i_in_item);
            if (o_out_valid && i_out_ready) sb.check_output(o_out_item);
        end
    end

    // Result-side back-pressure: mostly short bursts, occasional long runs
    // of ready, occasional long stalls, plus the single requested hold-off.
    initial begin
        int left;
        int r;
        left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                left = HOLD_CYCLES;
            end else if (left <= 1) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    i_out_ready <= 1'b1;
                    left = (r < 8) ? $urandom_range(40, 150) : $urandom_range(1, 8);
                end else begin
                    i_out_ready <= 1'b0;
                    left = (r > 97) ? $urandom_range(30, 80)
                         : (r > 90) ? $urandom_range(5, 20) : $urandom_range(1, 3);
                end
            end else begin
                left--;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic rlwl_pkg::t_in_item sample_item(input logic op, input int s,
                                                       input logic ch, input logic first,
                                                       input logic last);
        rlwl_pkg::t_in_item it;
        it.operation        = op;
        it.sample_in        = s[15:0];
        it.channel          = ch;
        it.first_of_channel = first;
        it.last_of_clip     = last;
        return it;
    endfunction

    // Level 0 straddles the RMS floor, level 3 is full-scale random.
    function automatic int draw_sample(input int level);
        int v;
        case (level)
            0: v = int'($urandom_range(0, 8)) - 4;
            1: v = int'($urandom_range(0, 600)) - 300;
            2: v = int'($urandom_range(0, 12000)) - 6000;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return v;
    endfunction

    // Mostly short clips; some run past the clip limit.
    function automatic int clip_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 24);
        if (r < 90) return $urandom_range(25, MAX_CLIP - 1);
        return $urandom_range(MAX_CLIP, MAX_CLIP + 12);
    endfunction

    // Called just after an edge; returns just after the accepting edge.
    task automatic send_item(input rlwl_pkg::t_in_item it);
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic pause();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else if (r < 98) n = $urandom_range(4, 10);
        else n = $urandom_range(20, 60);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering, let every owed result drain, then let trailing work settle.
    task automatic wait_idle(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rlwl_pkg::ADDR_W-1:0] addr,
                             input logic [rlwl_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [rlwl_pkg::ADDR_W-1:0] addr,
                             input logic [rlwl_pkg::DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("prdata at 0x%0h: expected 0x%0h, got 0x%0h", addr, want, prdata);
            sb.failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic configure(input logic [14:0] target, input logic smooth);
        write_reg(ADDR_TARGET, rlwl_pkg::DATA_W'(target));
        write_reg(ADDR_SMOOTH, rlwl_pkg::DATA_W'(smooth));
        sb.target = target;
        sb.smooth = smooth;
        check_reg(ADDR_TARGET, rlwl_pkg::DATA_W'(target));
        check_reg(ADDR_SMOOTH, rlwl_pkg::DATA_W'(smooth));
    endtask

    // One well-formed clip: analysis pass ending on the last flag, then a
    // processing pass with per-channel first flags. Out-of-pass flags are
    // sprinkled in as noise, and the processing length sometimes differs.
    task automatic run_clip(input int n, input int level, input bit hold_out);
        int   m;
        logic ch;
        logic first;
        logic seen[2];
        for (int i = 0; i < n; i++) begin
            send_item(sample_item(rlwl_pkg::OP_ANALYSIS, draw_sample(level),
                                  1'($urandom_range(0, 1)),
                                  $urandom_range(0, 7) == 0, i == n - 1));
            pause();
        end
        m = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n + 4) : n;
        seen[0] = 1'b0;
        seen[1] = 1'b0;
        if (hold_out) hold_req = 1'b1;
        for (int i = 0; i < m; i++) begin
            ch = 1'($urandom_range(0, 1));
            first = !seen[ch];
            seen[ch] = 1'b1;
            if ($urandom_range(0, 15) == 0) first = !first;
            send_item(sample_item(rlwl_pkg::OP_PROCESS,
                                  draw_sample(($urandom_range(0, 3) == 0) ? 3 : level),
                                  ch, first, $urandom_range(0, 7) == 0));
            pause();
        end
    endtask

    task automatic run_noise(input int n);
        for (int i = 0; i < n; i++) begin
            send_item(sample_item(1'($urandom_range(0, 1)), draw_sample(3),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
            pause();
        end
    endtask

    initial begin
        int          phase;
        logic [14:0] target;
        logic        smooth;
        sb = new();
        items_sent = 0;
        hold_req   = 1'b0;
        no_gaps    = 1'b1;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults after reset
        check_reg(ADDR_TARGET, rlwl_pkg::DATA_W'(rlwl_pkg::TARGET_RESET));
        check_reg(ADDR_SMOOTH, '0);

        // Full-scale extremes at default settings; a stray first flag in
        // analysis and a stray last flag in processing must be ignored.
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, 32767, 1'b0, 1'b1, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, -32768, 1'b1, 1'b0, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, 0, 1'b0, 1'b0, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, 1, 1'b1, 1'b0, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, -1, 1'b0, 1'b0, 1'b1));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, -32768, 1'b0, 1'b1, 1'b1));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, 32767, 1'b1, 1'b1, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, 0, 1'b0, 1'b0, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, -1, 1'b1, 1'b0, 1'b0));
        // near-silent clip: RMS under the floor gives unity gain
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, 2, 1'b0, 1'b0, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, -3, 1'b1, 1'b0, 1'b1));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, 32767, 1'b0, 1'b1, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, -32768, 1'b1, 1'b1, 1'b0));
        wait_idle(IDLE_SETTLE);

        // maximum target on a quiet clip hits the gain cap; lowpass on,
        // outputs saturate both ways
        configure(15'h7FFF, 1'b1);
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, 200, 1'b0, 1'b0, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, -200, 1'b1, 1'b0, 1'b1));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, 32767, 1'b0, 1'b1, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, 32767, 1'b0, 1'b0, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, -32768, 1'b1, 1'b1, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, -32768, 1'b1, 1'b0, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, 1, 1'b0, 1'b0, 1'b0));
        wait_idle(IDLE_SETTLE);

        // zero target: zero gain
        configure(15'd0, 1'b0);
        send_item(sample_item(rlwl_pkg::OP_ANALYSIS, 1000, 1'b0, 1'b0, 1'b1));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, 32767, 1'b0, 1'b1, 1'b0));
        send_item(sample_item(rlwl_pkg::OP_PROCESS, -5, 1'b1, 1'b1, 1'b0));

        // Random phases, each with its own settings. The sender drains the
        // block before every reconfiguration; phase 2 runs back to back and
        // carries the long receiver hold-off so the block backs up.
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            wait_idle(IDLE_SETTLE);
            case (phase % 6)
                0: target = 15'h7FFF;
                1: target = 15'd0;
                2: target = 15'd1;
                3: target = rlwl_pkg::TARGET_RESET;
                default: target = 15'($urandom_range(1, 32767));
            endcase
            smooth = (phase % 3 != 0);
            configure(target, smooth);
            no_gaps = (phase % 4 == 2);
            for (int c = 0; c < 3 && items_sent < ITEM_GOAL; c++) begin
                if (phase == 2 && c == 0) begin
                    run_clip(40, 2, 1'b1);
                end else if ($urandom_range(0, 99) < 85) begin
                    run_clip(clip_len(), $urandom_range(0, 3), 1'b0);
                end else begin
                    run_noise($urandom_range(4, 16));
                end
            end
            phase++;
        end

        wait_idle(END_SETTLE);
        if (sb.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
